[src/lpfg_pkg.sv]
// Shared types, constants and helper functions of the LED pattern frame generator.
`default_nettype none

package lpfg_pkg;

  localparam int MAX_LEDS_DEF = 32;
  localparam int LED_W        = 7;
  localparam int DIV_W        = 24;
  localparam int DIV_CNT_W    = $clog2(DIV_W + 1);
  localparam int POS_W        = 9;
  localparam int COLOR_W      = 24;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 24;
  localparam int Q_DEPTH      = 2;

  localparam logic [POS_W:0]     WHEEL_STEPS      = 10'd384;
  localparam logic [POS_W:0]     WHEEL_THIRD      = 10'd128;
  localparam logic [POS_W:0]     WHEEL_TWO_THIRDS = 10'd256;
  localparam logic [DIV_W-1:0]   WHEEL_SCALE      = 24'd3840;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LED_COUNT      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RAINBOW_SPREAD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPAN_TOTAL     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BAR_COLOR      = 3'd4;

  typedef enum logic [1:0] {
    MODE_WHEEL = 2'd0,
    MODE_FILL  = 2'd1,
    MODE_DRAIN = 2'd2,
    MODE_DARK  = 2'd3
  } mode_e;

  typedef struct packed {
    mode_e               mode;
    logic [5:0]          led_count;
    logic [15:0]         spread;
    logic [15:0]         span;
    logic [COLOR_W-1:0]  color;
  } cfg_t;

  typedef struct packed {
    mode_e               mode;
    logic [LED_W-1:0]    n;
    logic [LED_W-1:0]    bar_len;
    logic [POS_W-1:0]    phase;
    logic [POS_W-1:0]    q1m;
    logic [DIV_W-1:0]    r1;
    logic [DIV_W-1:0]    d;
    logic [COLOR_W-1:0]  color;
  } job_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  num;
    logic [DIV_W-1:0]  den;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DIV_W-1:0]  quo;
    logic [DIV_W-1:0]  rem;
  } div_rsp_t;

  // Since 384 is 3 * 128, the residue splits into the low seven bits and the
  // upper part taken mod 3, which is the sum of its base-4 digits mod 3.
  function automatic logic [POS_W-1:0] mod384(input logic [15:0] x);
    logic [3:0] s;
    logic [1:0] m;
    s = 4'(x[8:7]) + 4'(x[10:9]) + 4'(x[12:11]) + 4'(x[14:13]) + 4'(x[15]);
    case (s)
      4'd0, 4'd3, 4'd6, 4'd9, 4'd12, 4'd15: m = 2'd0;
      4'd1, 4'd4, 4'd7, 4'd10, 4'd13:       m = 2'd1;
      default:                              m = 2'd2;
    endcase
    return {m, x[6:0]};
  endfunction

  function automatic logic [POS_W-1:0] wheel_add(input logic [POS_W-1:0] p,
                                                 input logic [POS_W:0] off);
    logic [POS_W:0] t;
    t = {1'b0, p} + off;
    if (t >= WHEEL_STEPS) begin
      t = t - WHEEL_STEPS;
    end
    return t[POS_W-1:0];
  endfunction

  // The triangle level is at most 127, where multiplying by 205 and dropping
  // eleven bits equals a truncating division by ten.
  function automatic logic [7:0] wheel_level(input logic [POS_W-1:0] p);
    logic [7:0]  v;
    logic [15:0] prod;
    if (p < 9'd128) begin
      v = p[7:0];
    end else if (p < 9'd256) begin
      v = 8'(9'd255 - p);
    end else begin
      v = 8'd0;
    end
    prod = 16'(v) * 16'd205;
    return 8'(prod[15:11]);
  endfunction

endpackage

`default_nettype wire

[src/lpfg_div.sv]
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none

module lpfg_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lpfg_pkg::div_req_t req_i,
  output lpfg_pkg::div_rsp_t rsp_o
);
  import lpfg_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_W-1:0]     rem_q, quo_q, den_q;
  logic [DIV_W:0]       trial;
  logic                 take;

  assign trial = {rem_q, quo_q[DIV_W-1]};
  assign take  = trial >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(DIV_W);
    end else if (busy_q) begin
      cnt_d = cnt_q - DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.num;
      den_q <= req_i.den;
    end else if (busy_q) begin
      rem_q <= take ? DIV_W'(trial - {1'b0, den_q}) : trial[DIV_W-1:0];
      quo_q <= {quo_q[DIV_W-2:0], take};
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule

`default_nettype wire

[src/lpfg_front.sv]
// Front end: accepts frame counters and works out the per-frame job setup.
`default_nettype none

module lpfg_front #(
  parameter int MAX_LEDS = lpfg_pkg::MAX_LEDS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [15:0]        frame_counter_i,
  input  lpfg_pkg::cfg_t     cfg_i,
  output lpfg_pkg::div_req_t div_req_o,
  input  lpfg_pkg::div_rsp_t div_rsp_i,
  output logic               q_push_o,
  output lpfg_pkg::job_t     q_job_o,
  input  logic               q_full_i
);
  import lpfg_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_PUSH = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [15:0]      counter_q;
  logic [DIV_W-1:0] den_q;
  job_t             job_q;
  logic [LED_W-1:0] n_sat;
  logic [LED_W-1:0] np1;
  logic [16:0]      spread_p1;
  logic [15:0]      total;
  logic [15:0]      rest;
  logic [DIV_W-1:0] num, den;
  logic             accept;

  assign n_sat = (LED_W'(cfg_i.led_count) > LED_W'(MAX_LEDS)) ?
                 LED_W'(MAX_LEDS) : LED_W'(cfg_i.led_count);
  assign np1       = job_q.n + LED_W'(1);
  assign spread_p1 = {1'b0, cfg_i.spread} + 17'd1;
  assign total     = (cfg_i.span == 16'd0) ? 16'd1 : cfg_i.span;
  assign rest      = (cfg_i.span >= counter_q) ? (cfg_i.span - counter_q) : 16'd0;

  always_comb begin
    case (job_q.mode)
      MODE_WHEEL: begin
        num = WHEEL_SCALE;
        den = DIV_W'(job_q.n) * DIV_W'(spread_p1);
      end
      MODE_FILL: begin
        num = DIV_W'(counter_q) * DIV_W'(np1);
        den = DIV_W'(total);
      end
      MODE_DRAIN: begin
        num = DIV_W'(rest) * DIV_W'(np1);
        den = DIV_W'(cfg_i.span) + DIV_W'(1);
      end
      default: begin
        num = '0;
        den = DIV_W'(1);
      end
    endcase
  end

  assign accept          = in_valid_i && in_ready_o;
  assign in_ready_o      = (state_q == ST_IDLE);
  assign div_req_o.start = (state_q == ST_MUL);
  assign div_req_o.num   = num;
  assign div_req_o.den   = den;
  assign q_push_o        = (state_q == ST_PUSH) && !q_full_i;
  assign q_job_o         = job_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && n_sat != '0) begin
          state_d = (cfg_i.mode == MODE_DARK) ? ST_PUSH : ST_MUL;
        end
      end
      ST_MUL: begin
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_rsp_i.done) begin
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (!q_full_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      counter_q     <= frame_counter_i;
      job_q.mode    <= cfg_i.mode;
      job_q.n       <= n_sat;
      job_q.bar_len <= '0;
      job_q.phase   <= mod384(frame_counter_i);
      job_q.q1m     <= '0;
      job_q.r1      <= '0;
      job_q.d       <= '0;
      job_q.color   <= cfg_i.color;
    end
    if (state_q == ST_MUL) begin
      den_q <= den;
    end
    if (state_q == ST_DIV && div_rsp_i.done) begin
      if (job_q.mode == MODE_WHEEL) begin
        job_q.q1m <= mod384(div_rsp_i.quo[15:0]);
        job_q.r1  <= div_rsp_i.rem;
        job_q.d   <= den_q;
      end else begin
        job_q.bar_len <= (div_rsp_i.quo > DIV_W'(job_q.n)) ?
                         job_q.n : div_rsp_i.quo[LED_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

[src/lpfg_queue.sv]
// Short job queue between the front end and the LED emitter.
`default_nettype none

module lpfg_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  lpfg_pkg::job_t job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output lpfg_pkg::job_t job_o
);
  import lpfg_pkg::*;

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  job_t             entries_q [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  assign full_o  = (count_q == CNT_W'(Q_DEPTH));
  assign valid_o = (count_q != '0);
  assign job_o   = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

`default_nettype wire

[src/lpfg_back.sv]
// Back end: walks the LEDs of one job and drives the registered output word.
`default_nettype none

module lpfg_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           job_valid_i,
  input  lpfg_pkg::job_t job_i,
  output logic           job_pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [4:0]     led_index_o,
  output logic [7:0]     red_level_o,
  output logic [7:0]     green_level_o,
  output logic [7:0]     blue_level_o,
  output logic           last_led_o
);
  import lpfg_pkg::*;

  logic             active_q;
  logic             out_valid_q;
  job_t             job_q;
  logic [LED_W-1:0] idx_q;
  logic [POS_W-1:0] pos_q, pos_n;
  logic [DIV_W-1:0] rem_q, rem_n;
  logic [DIV_W:0]   rsum;
  logic             carry;
  logic [POS_W:0]   inc, psum;
  logic [7:0]       r, g, b;
  logic             last;
  logic             emit;
  logic [4:0]       led_index_q;
  logic [7:0]       red_q, green_q, blue_q;
  logic             last_q;

  assign job_pop_o = job_valid_i && !active_q;
  assign emit      = active_q && (!out_valid_q || out_ready_i);
  assign last      = (idx_q + LED_W'(1)) == job_q.n;

  // Wheel position of the next LED follows from the per-LED quotient step
  // and the remainder carried across LEDs.
  assign rsum  = {1'b0, rem_q} + {1'b0, job_q.r1};
  assign carry = rsum >= {1'b0, job_q.d};
  assign rem_n = carry ? DIV_W'(rsum - {1'b0, job_q.d}) : rsum[DIV_W-1:0];
  assign inc   = {1'b0, job_q.q1m} + (POS_W + 1)'(carry);
  assign psum  = {1'b0, pos_q} + inc;
  assign pos_n = (psum >= WHEEL_STEPS) ? POS_W'(psum - WHEEL_STEPS) : psum[POS_W-1:0];

  always_comb begin
    r = 8'd0;
    g = 8'd0;
    b = 8'd0;
    case (job_q.mode)
      MODE_WHEEL: begin
        r = wheel_level(pos_q);
        g = wheel_level(wheel_add(pos_q, WHEEL_THIRD));
        b = wheel_level(wheel_add(pos_q, WHEEL_TWO_THIRDS));
      end
      MODE_FILL, MODE_DRAIN: begin
        if (idx_q < job_q.bar_len) begin
          r = job_q.color[23:16];
          g = job_q.color[15:8];
          b = job_q.color[7:0];
        end
      end
      default: begin
        r = 8'd0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (job_pop_o) begin
        active_q <= 1'b1;
      end else if (emit && last) begin
        active_q <= 1'b0;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      job_q <= job_i;
      idx_q <= '0;
      pos_q <= job_i.phase;
      rem_q <= '0;
    end else if (emit) begin
      idx_q <= idx_q + LED_W'(1);
      pos_q <= pos_n;
      rem_q <= rem_n;
    end
    if (emit) begin
      led_index_q <= idx_q[4:0];
      red_q       <= r;
      green_q     <= g;
      blue_q      <= b;
      last_q      <= last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign led_index_o   = led_index_q;
  assign red_level_o   = red_q;
  assign green_level_o = green_q;
  assign blue_level_o  = blue_q;
  assign last_led_o    = last_q;

endmodule

`default_nettype wire

[src/led_pattern_frame_generator_top.sv]
// Top level of the LED pattern frame generator: registers, front, divider, queue, back.
//
// Each word on the input channel is a frame counter. For it the block sends
// one output word per LED of the strip, index 0 first, with last_led_o set on
// the final LED; a zero LED count yields no output words.
// Registers are written over the cfg channel, which is always ready, and must
// only change while no frame is in flight.
// A frame's setup waits on the 24-step divider that the front end drives,
// except in dark mode, which skips it. A two-entry job queue lets the front
// prepare the next frame while the back end emits, one LED per cycle while
// the receiver is ready, after it loads the job from the queue.
// When the receiver stalls, the output word holds and the back end waits;
// the front keeps working until the queue is full and then drops in_ready_o.
// Reset empties the queue and the output register and loads the register
// defaults: rainbow mode, 20 LEDs, spread 42, span 1, dark bar color.
`default_nettype none

module led_pattern_frame_generator_top #(
  parameter int MAX_LEDS = lpfg_pkg::MAX_LEDS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [lpfg_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [lpfg_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [15:0]                    frame_counter_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [4:0]                     led_index_o,
  output logic [7:0]                     red_level_o,
  output logic [7:0]                     green_level_o,
  output logic [7:0]                     blue_level_o,
  output logic                           last_led_o
);
  import lpfg_pkg::*;

  cfg_t     cfg_q;
  div_req_t div_req;
  div_rsp_t div_rsp;
  logic     q_push, q_full, q_valid, q_pop;
  job_t     q_in_job, q_out_job;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode      <= MODE_WHEEL;
      cfg_q.led_count <= 6'd20;
      cfg_q.spread    <= 16'd42;
      cfg_q.span      <= 16'd1;
      cfg_q.color     <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_PATTERN_MODE:   cfg_q.mode      <= mode_e'(cfg_data_i[1:0]);
        REG_LED_COUNT:      cfg_q.led_count <= cfg_data_i[5:0];
        REG_RAINBOW_SPREAD: cfg_q.spread    <= cfg_data_i[15:0];
        REG_SPAN_TOTAL:     cfg_q.span      <= cfg_data_i[15:0];
        REG_BAR_COLOR:      cfg_q.color     <= cfg_data_i[COLOR_W-1:0];
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  lpfg_front #(
    .MAX_LEDS(MAX_LEDS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .frame_counter_i(frame_counter_i),
    .cfg_i          (cfg_q),
    .div_req_o      (div_req),
    .div_rsp_i      (div_rsp),
    .q_push_o       (q_push),
    .q_job_o        (q_in_job),
    .q_full_i       (q_full)
  );

  lpfg_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  lpfg_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .job_i  (q_in_job),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .job_o  (q_out_job)
  );

  lpfg_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_valid_i  (q_valid),
    .job_i        (q_out_job),
    .job_pop_o    (q_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .led_index_o  (led_index_o),
    .red_level_o  (red_level_o),
    .green_level_o(green_level_o),
    .blue_level_o (blue_level_o),
    .last_led_o   (last_led_o)
  );

  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("Divider restarted while a division was running.");

  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("Job pushed into a full queue.");

  a_pop_has_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("Job popped from an empty queue.");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |=> !div_rsp.done)
    else $error("Divider done held for more than one cycle.");

endmodule

`default_nettype wire
